>>> rtl/core/mlp_pkg.sv
// package for the mlp inference engine: item structs, request codes, config indexes
// and the activation codes used by the datapath
// no dependencies
`default_nettype none
package mlp_pkg;

  localparam logic [1:0] REQ_WEIGHT = 2'd0;
  localparam logic [1:0] REQ_BIAS   = 2'd1;
  localparam logic [1:0] REQ_INPUT  = 2'd2;
  localparam logic [1:0] REQ_RUN    = 2'd3;

  localparam logic [2:0] CFG_NUM_LAYERS = 3'd0;
  localparam logic [2:0] CFG_SIZE0      = 3'd1;
  localparam logic [2:0] CFG_SIZE1      = 3'd2;
  localparam logic [2:0] CFG_SIZE2      = 3'd3;
  localparam logic [2:0] CFG_SIZE3      = 3'd4;
  localparam logic [2:0] CFG_BIAS_MASK  = 3'd5;
  localparam logic [2:0] CFG_ACT_CODES  = 3'd6;
  localparam logic [2:0] CFG_OUT_SCALE  = 3'd7;

  localparam logic [1:0] ACT_LOGISTIC = 2'd0;
  localparam logic [1:0] ACT_TANH     = 2'd2;

  // number of size registers that exist
  localparam int SizeRegs = 4;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [15:0]        index;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         unit_index;
    logic signed [31:0] result_value;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  addr;
    logic [15:0] data;
  } cfg_item_t;

endpackage
`default_nettype wire

>>> rtl/core/mlp_inference_engine_unit.sv
// mlp inference engine top level: weight, bias and activation memories, run sequencer
// loads are taken while the sequencer is idle; a run multiplies each weight with its input
// through the product pipeline, then per unit adds the bias, applies the activation and
// writes the result back or emits it, stalling while the output register is held off
// reset clears the configuration to its defaults and idles the sequencer; memories
// are not cleared. results leave through a one-item output register
`default_nettype none
module mlp_inference_engine_unit #(
  parameter int MAX_LAYERS   = 4,
  parameter int MAX_UNITS    = 512,
  parameter int WEIGHT_DEPTH = 65536,
  parameter int FRAC_BITS    = 12,
  parameter int MAX_OUTPUTS  = 64
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire mlp_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output mlp_pkg::out_item_t   out_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire mlp_pkg::cfg_item_t cfg_data
);

  localparam int NL      = (MAX_LAYERS < mlp_pkg::SizeRegs) ? MAX_LAYERS : mlp_pkg::SizeRegs;
  localparam int UW      = $clog2(MAX_UNITS);
  localparam int SW      = UW + 1;
  localparam int WAW     = $clog2(WEIGHT_DEPTH);
  localparam int BDEPTH  = MAX_LAYERS * MAX_UNITS;
  localparam int BAW     = $clog2(BDEPTH);
  localparam int LW      = $clog2(MAX_LAYERS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAC   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_ACT   = 3'd3;
  localparam logic [2:0] ST_STORE = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;
  localparam logic [2:0] ST_EMUL  = 3'd6;

  // configuration
  logic [2:0]  num_layers;
  logic [9:0]  size_reg [4];
  logic [3:0]  bias_mask;
  logic [7:0]  act_codes;
  logic [15:0] out_scale;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_layers  <= 3'd4;
      size_reg[0] <= 10'd262;
      size_reg[1] <= 10'd66;
      size_reg[2] <= 10'd256;
      size_reg[3] <= 10'd1;
      bias_mask   <= 4'd14;
      act_codes   <= 8'd170;
      out_scale   <= 16'd29744;
    end else if (cfg_valid) begin
      unique case (cfg_data.addr)
        mlp_pkg::CFG_NUM_LAYERS: num_layers  <= cfg_data.data[2:0];
        mlp_pkg::CFG_SIZE0:      size_reg[0] <= cfg_data.data[9:0];
        mlp_pkg::CFG_SIZE1:      size_reg[1] <= cfg_data.data[9:0];
        mlp_pkg::CFG_SIZE2:      size_reg[2] <= cfg_data.data[9:0];
        mlp_pkg::CFG_SIZE3:      size_reg[3] <= cfg_data.data[9:0];
        mlp_pkg::CFG_BIAS_MASK:  bias_mask   <= cfg_data.data[3:0];
        mlp_pkg::CFG_ACT_CODES:  act_codes   <= cfg_data.data[7:0];
        mlp_pkg::CFG_OUT_SCALE:  out_scale   <= cfg_data.data;
        default: ;
      endcase
    end
  end

  function automatic logic [SW-1:0] clamp_size(input logic [9:0] s);
    if (s == 10'd0) return SW'(1);
    if (32'(s) > MAX_UNITS) return SW'(MAX_UNITS);
    return SW'(s);
  endfunction

  // memories
  logic signed [15:0] wmem [WEIGHT_DEPTH];
  logic signed [15:0] bmem [BDEPTH];
  logic signed [15:0] amem [2*MAX_UNITS];

  logic               w_we, b_we, a_we;
  logic [WAW-1:0]     w_waddr, w_raddr;
  logic [BAW-1:0]     b_waddr, b_raddr;
  logic [UW:0]        a_waddr, a_raddr;
  logic signed [15:0] w_wdata, b_wdata, a_wdata;
  logic signed [15:0] w_rdata, b_rdata, a_rdata;

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= w_wdata;
    w_rdata <= wmem[w_raddr];
  end
  always_ff @(posedge clk) begin
    if (b_we) bmem[b_waddr] <= b_wdata;
    b_rdata <= bmem[b_raddr];
  end
  always_ff @(posedge clk) begin
    if (a_we) amem[a_waddr] <= a_wdata;
    a_rdata <= amem[a_raddr];
  end

  // sequencer state
  logic [2:0]     state;
  logic [LW:0]    layer;
  logic [LW:0]    nlay;
  logic [SW-1:0]  cur, low;
  logic [SW-1:0]  j;
  logic [SW-1:0]  k;
  logic [WAW-1:0] waddr;
  logic           rd_vld;
  logic [39:0]    acc;
  logic signed [31:0] prod;
  logic           prod_vld;
  logic           drain_cnt;
  logic signed [41:0] act;
  logic           out_full;
  logic [1:0]     code;
  logic           bias_on;
  logic           last_layer;

  logic [2:0] nl_raw;
  always_comb begin
    nl_raw = num_layers;
    if (nl_raw < 3'd2) nl_raw = 3'd2;
    if (32'(nl_raw) > NL) nl_raw = 3'(NL);
  end

  assign code       = act_codes[2*layer[1:0] +: 2];
  assign bias_on    = bias_mask[layer[1:0]];
  assign last_layer = (layer + 1'b1 == nlay);

  mlp_act #(.FRAC_BITS(FRAC_BITS)) u_act (
    .clk  (clk),
    .acc  (acc),
    .code (code),
    .act  (act)
  );

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    w_we    = in_valid && in_ready && in_data.req_type == mlp_pkg::REQ_WEIGHT;
    w_waddr = WAW'(in_data.index);
    w_wdata = in_data.value;
    b_we    = in_valid && in_ready && in_data.req_type == mlp_pkg::REQ_BIAS;
    b_waddr = BAW'(32'(in_data.index) % BDEPTH);
    b_wdata = in_data.value;
    w_raddr = waddr;
    b_raddr = BAW'(layer) * BAW'(MAX_UNITS) + BAW'(j);
    a_raddr = {~layer[0], UW'(k)};
    // output-layer units are never written back
    if (state == ST_STORE && !last_layer) begin
      a_we    = 1'b1;
      a_waddr = {layer[0], UW'(j)};
      a_wdata = (act > 42'sd32767) ? 16'sh7fff :
                (act < -42'sd32768) ? 16'sh8000 : act[15:0];
    end else begin
      a_we    = in_valid && in_ready && in_data.req_type == mlp_pkg::REQ_INPUT;
      a_waddr = {1'b0, UW'(in_data.index)};
      a_wdata = in_data.value;
    end
  end

  logic signed [41:0] act_hold;
  logic signed [58:0] scaled;
  logic [SW-1:0] emitted;
  assign emitted = (32'(cur) < MAX_OUTPUTS) ? cur : SW'(MAX_OUTPUTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      out_full <= 1'b0;
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_EMUL) out_full <= 1'b0;
      // product pipeline: memory data -> registered product -> accumulator
      prod     <= w_rdata * a_rdata;
      prod_vld <= rd_vld;
      if (prod_vld) acc <= acc + 40'($signed(prod));
      rd_vld <= (state == ST_MAC);
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_data.req_type == mlp_pkg::REQ_RUN) begin
            nlay  <= (LW+1)'(nl_raw);
            layer <= (LW+1)'(1);
            cur   <= clamp_size(size_reg[1]);
            low   <= clamp_size(size_reg[0]);
            j     <= '0;
            k     <= '0;
            waddr <= '0;
            acc   <= '0;
            state <= ST_MAC;
          end
        end
        ST_MAC: begin
          waddr  <= waddr + 1'b1;
          if (k + 1'b1 == low) begin
            k         <= '0;
            drain_cnt <= 1'b0;
            state     <= ST_DRAIN;
          end else begin
            k <= k + 1'b1;
          end
        end
        ST_DRAIN: begin
          // wait for the last product to land, then fold in the bias
          if (!rd_vld && !prod_vld) begin
            if (!drain_cnt) drain_cnt <= 1'b1;
            else begin
              if (bias_on) acc <= acc + 40'($signed({b_rdata, FRAC_BITS'(0)}));
              state <= ST_ACT;
            end
          end
        end
        ST_ACT: begin
          state <= last_layer ? ST_EMIT : ST_STORE;
        end
        ST_STORE: begin
          state <= ST_MAC;
          acc   <= '0;
          if (j + 1'b1 == cur) begin
            j     <= '0;
            layer <= layer + 1'b1;
            low   <= cur;
            cur   <= clamp_size(size_reg[2'(layer + 1'b1)]);
          end else begin
            j <= j + 1'b1;
          end
        end
        ST_EMIT: begin
          act_hold <= act;
          if (32'(j) < MAX_OUTPUTS) state <= ST_EMUL;
          else if (j + 1'b1 == cur) state <= ST_IDLE;
          else state <= ST_STORE;
        end
        ST_EMUL: begin
          if (!out_full || out_ready) begin
            out_full              <= 1'b1;
            out_data.unit_index   <= 6'(j);
            out_data.last         <= (j + 1'b1 == emitted);
            out_data.result_value <= (scaled > 59'sh7fffffff) ? 32'sh7fffffff :
                                     (scaled < -59'sh80000000) ? 32'sh80000000 :
                                     scaled[31:0];
            acc <= '0;
            if (j + 1'b1 == cur) begin
              state <= ST_IDLE;
            end else begin
              j     <= j + 1'b1;
              state <= ST_MAC;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign scaled    = act_hold * $signed({1'b0, out_scale});
  assign out_valid = out_full;

endmodule
`default_nettype wire

>>> rtl/core/mlp_act.sv
// activation unit: rounding of the accumulator, logistic / tanh / linear by
// piecewise-linear segments, registered result; uses mlp_pkg
`default_nettype none
module mlp_act #(
  parameter int FRAC_BITS = 12
) (
  input  wire                clk,
  input  wire         [39:0] acc,
  input  wire          [1:0] code,
  output logic signed [41:0] act
);

  localparam int             AW  = 42;
  localparam logic [AW-1:0]  ONE = AW'(1) << FRAC_BITS;

  logic signed [40:0] rnd;
  logic signed [AW-1:0] q;
  logic signed [AW-1:0] x2;
  logic signed [AW-1:0] act_next;

  function automatic logic signed [AW-1:0] logistic(input logic signed [AW-1:0] x);
    logic [AW-1:0] ax;
    logic [AW-1:0] y;
    ax = x[AW-1] ? AW'(-x) : AW'(x);
    if (ax >= 5 * ONE) y = ONE;
    else if (ax >= (19 * ONE) / 8) y = (ax >> 5) + (27 * ONE) / 32;
    else if (ax >= ONE) y = (ax >> 3) + (5 * ONE) / 8;
    else y = (ax >> 2) + ONE / 2;
    return x[AW-1] ? $signed(ONE - y) : $signed(y);
  endfunction

  always_comb begin
    rnd      = $signed({acc[39], acc}) + 41'sd1 <<< 0;
    rnd      = $signed({acc[39], acc}) + $signed(41'(1) << (FRAC_BITS - 1));
    q        = AW'(rnd >>> FRAC_BITS);
    x2       = q <<< 1;
    case (code)
      mlp_pkg::ACT_LOGISTIC: act_next = logistic(q);
      mlp_pkg::ACT_TANH:     act_next = (logistic(x2) <<< 1) - $signed(ONE);
      default:               act_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    act <= act_next;
  end

endmodule
`default_nettype wire

>>> test/mlp_checker.sv
// checker for the mlp inference engine: watches the load, run, config and result channels,
// predicts every result of a run and compares it with what the block emits
// depends on mlp_pkg
`timescale 1ns / 100ps
module mlp_checker
  import mlp_pkg::*;
(
  input  wire       clk,
  input  wire       rst,
  input  wire       in_valid,
  input  wire       in_ready,
  input  in_item_t  in_data,
  input  wire       out_valid,
  input  wire       out_ready,
  input  out_item_t out_data,
  input  wire       cfg_valid,
  input  wire       cfg_ready,
  input  cfg_item_t cfg_data,
  output int        errors,
  output int        pending
);

  logic signed [15:0] weights [65536];
  logic signed [15:0] biases [2048];
  logic signed [15:0] acts [2][512];

  logic [2:0]  num_layers;
  logic [9:0]  sizes [4];
  logic [3:0]  bias_mask;
  logic [7:0]  act_codes;
  logic [15:0] out_scale;

  out_item_t unit_results [$];

  initial begin
    errors = 0;
    pending = 0;
  end

  function automatic int units(int i);
    if (sizes[i] == 0) return 1;
    if (sizes[i] > 512) return 512;
    return int'(sizes[i]);
  endfunction

  function automatic longint logistic(longint x);
    longint ax, y;
    ax = (x < 0) ? -x : x;
    if (ax >= 20480) y = 4096;
    else if (ax >= 9728) y = (ax >>> 5) + 3456;
    else if (ax >= 4096) y = (ax >>> 3) + 2560;
    else y = (ax >>> 2) + 2048;
    return (x < 0) ? 4096 - y : y;
  endfunction

  function automatic longint activate(logic [1:0] code, longint x);
    if (code == ACT_LOGISTIC) return logistic(x);
    if (code == ACT_TANH) return 2 * logistic(2 * x) - 4096;
    return x;
  endfunction

  task automatic forward_pass();
    int n, cur, low, base, emitted;
    logic [39:0] acc;
    longint prod, net, q, a, r;
    logic [1:0] code;
    out_item_t o;
    n = int'(num_layers);
    if (n < 2) n = 2;
    if (n > 4) n = 4;
    base = 0;
    for (int i = 1; i < n; i++) begin
      cur = units(i);
      low = units(i - 1);
      code = act_codes[2 * i +: 2];
      for (int j = 0; j < cur; j++) begin
        acc = '0;
        for (int k = 0; k < low; k++) begin
          prod = longint'(weights[(base + j * low + k) % 65536]) * longint'(acts[(i - 1) % 2][k]);
          acc = acc + prod[39:0];
        end
        if (bias_mask[i]) begin
          prod = longint'(biases[i * 512 + j]) <<< 12;
          acc = acc + prod[39:0];
        end
        net = longint'(signed'(acc));
        q = (net + 2048) >>> 12;
        a = activate(code, q);
        if (i < n - 1) begin
          if (a > 32767) acts[i % 2][j] = 16'sd32767;
          else if (a < -32768) acts[i % 2][j] = -16'sd32768;
          else acts[i % 2][j] = a[15:0];
        end else if (j < 64) begin
          r = a * longint'(out_scale);
          if (r > 64'sd2147483647) r = 64'sd2147483647;
          if (r < -64'sd2147483648) r = -64'sd2147483648;
          emitted = (cur < 64) ? cur : 64;
          o.unit_index = j[5:0];
          o.result_value = r[31:0];
          o.last = (j + 1 == emitted);
          unit_results.push_back(o);
        end
      end
      base += cur * low;
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      num_layers = 3'd4;
      sizes[0] = 10'd262;
      sizes[1] = 10'd66;
      sizes[2] = 10'd256;
      sizes[3] = 10'd1;
      bias_mask = 4'd14;
      act_codes = 8'd170;
      out_scale = 16'd29744;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_data.addr)
          CFG_NUM_LAYERS: num_layers = cfg_data.data[2:0];
          CFG_SIZE0:      sizes[0] = cfg_data.data[9:0];
          CFG_SIZE1:      sizes[1] = cfg_data.data[9:0];
          CFG_SIZE2:      sizes[2] = cfg_data.data[9:0];
          CFG_SIZE3:      sizes[3] = cfg_data.data[9:0];
          CFG_BIAS_MASK:  bias_mask = cfg_data.data[3:0];
          CFG_ACT_CODES:  act_codes = cfg_data.data[7:0];
          CFG_OUT_SCALE:  out_scale = cfg_data.data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (in_data.req_type)
          REQ_WEIGHT: weights[in_data.index] = in_data.value;
          REQ_BIAS:   biases[in_data.index[10:0]] = in_data.value;
          REQ_INPUT:  acts[0][in_data.index[8:0]] = in_data.value;
          REQ_RUN:    forward_pass();
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (unit_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("result with nothing expected: unit %0d value %0d last %0b",
                     out_data.unit_index, out_data.result_value, out_data.last);
        end else begin
          e = unit_results.pop_front();
          if (e.unit_index !== out_data.unit_index || e.result_value !== out_data.result_value ||
              e.last !== out_data.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected unit %0d value %0d last %0b, got unit %0d value %0d last %0b",
                       e.unit_index, e.result_value, e.last,
                       out_data.unit_index, out_data.result_value, out_data.last);
          end
        end
      end
    end
    pending = unit_results.size();
  end

endmodule

>>> test/tb_top.sv
// top of the mlp inference engine testbench: clock, reset, load and run stimulus,
// result back-pressure and verdict; depends on mlp_pkg, mlp_checker and the block
`timescale 1ns / 100ps
module tb_top;
  import mlp_pkg::*;

  localparam int CycleLimit = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_item_t cfg_data = '0;
  int errors, pending;
  int cycles = 0;
  bit hold_req = 0;

  mlp_inference_engine_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  mlp_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_value();
    if ($urandom_range(0, 4) != 0) return 16'($urandom);
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return 16'h1000;
      default: return 16'hf000;
    endcase
  endfunction

  // receiver: random stalls, and one long hold-off on request
  initial begin
    int stall, hold_cnt;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < 500; hold_cnt++) @(posedge clk);
        hold_req = 0;
      end else begin
        if (stall == 0 && $urandom_range(0, 7) == 0) stall = pick_gap();
        if (stall > 0) stall--;
        out_ready <= (stall == 0);
      end
    end
  end

  task automatic send_item(logic [1:0] req, logic [15:0] idx, logic [15:0] val);
    int gap;
    bit hs;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{req_type: req, index: idx, value: val};
    forever begin
      @(negedge clk);
      hs = in_ready;
      @(posedge clk);
      if (hs) break;
    end
  endtask

  task automatic write_reg(logic [2:0] addr, logic [15:0] data);
    bit hs;
    cfg_valid <= 1'b1;
    cfg_data <= '{addr: addr, data: data};
    forever begin
      @(negedge clk);
      hs = cfg_ready;
      @(posedge clk);
      if (hs) break;
    end
  endtask

  // sender stops until every predicted result has come and the block is idle again
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0 || !in_ready);
    repeat (40) @(posedge clk);
  endtask

  task automatic network_phase(int nl, int s0, int s1, int s2, int s3, int mask, int codes,
                               int scale, int runs, bit squeeze);
    int n, base, kind, i, t;
    int sz [4];
    write_reg(CFG_NUM_LAYERS, 16'(nl));
    write_reg(CFG_SIZE0, 16'(s0));
    write_reg(CFG_SIZE1, 16'(s1));
    write_reg(CFG_SIZE2, 16'(s2));
    write_reg(CFG_SIZE3, 16'(s3));
    write_reg(CFG_BIAS_MASK, 16'(mask));
    write_reg(CFG_ACT_CODES, 16'(codes));
    write_reg(CFG_OUT_SCALE, 16'(scale));
    cfg_valid <= 1'b0;
    n = (nl < 2) ? 2 : ((nl > 4) ? 4 : nl);
    sz[0] = s0; sz[1] = s1; sz[2] = s2; sz[3] = s3;
    for (i = 0; i < 4; i++) sz[i] = (sz[i] == 0) ? 1 : ((sz[i] > 512) ? 512 : sz[i]);
    // full load of every weight, bias and input the run reads
    base = 0;
    for (i = 1; i < n; i++) begin
      for (t = 0; t < sz[i] * sz[i - 1]; t++)
        send_item(REQ_WEIGHT, 16'(base + t), pick_value());
      base += sz[i] * sz[i - 1];
      if (((mask >> i) & 1) != 0) begin
        for (t = 0; t < sz[i]; t++)
          send_item(REQ_BIAS, 16'(i * 512 + t + 2048 * $urandom_range(0, 31)), pick_value());
      end
    end
    for (t = 0; t < sz[0]; t++)
      send_item(REQ_INPUT, 16'(t + 512 * $urandom_range(0, 127)), pick_value());
    if (squeeze) hold_req = 1;
    for (int r = 0; r < runs; r++) begin
      if (!squeeze) begin
        repeat ($urandom_range(0, 4)) begin
          kind = $urandom_range(0, 9);
          if (kind < 5) send_item(REQ_WEIGHT, 16'($urandom_range(0, base - 1)), pick_value());
          else if (kind < 7)
            send_item(REQ_BIAS,
                      16'($urandom_range(1, n - 1) * 512 + $urandom_range(0, sz[1] - 1)),
                      pick_value());
          else if (kind < 9)
            send_item(REQ_INPUT, 16'($urandom_range(0, sz[0] - 1)), pick_value());
          else send_item(2'($urandom_range(0, 2)), 16'($urandom), pick_value());
        end
      end
      send_item(REQ_RUN, 16'($urandom), 16'($urandom));
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed settings: single units, wide output, zero and full scale, every activation
    network_phase(2, 1, 1, 0, 0, 0, 8'h00, 1, 3, 0);
    network_phase(2, 0, 70, 7, 9, 1, 8'h08, 65535, 2, 0);
    network_phase(3, 3, 4, 5, 1, 15, 8'h1c, 0, 3, 0);
    network_phase(4, 4, 3, 3, 2, 14, 8'haa, 29744, 3, 0);
    network_phase(7, 2, 2, 3, 3, 9, 8'h64, 300, 12, 1);
    network_phase(0, 3, 1, 0, 0, 3, 8'hff, 4096, 2, 0);
    // random settings, mostly small layers
    repeat (3) begin
      network_phase($urandom_range(2, 4), $urandom_range(0, 5), $urandom_range(0, 6),
                    $urandom_range(0, 5), $urandom_range(0, 6), $urandom_range(0, 15),
                    $urandom_range(0, 255), $urandom_range(0, 65535), $urandom_range(3, 8), 0);
    end
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
